/* hw/rtl/psot_pkg.sv */
package psot_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_BOX_WIDTH   = 2'd0;
  localparam logic [1:0] REG_BOX_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_SIDE_LENGTH = 2'd2;

  localparam logic [31:0] BOX_RESET  = 32'd4194304;
  localparam logic [22:0] SIDE_RESET = 23'd65536;

  // Depth of the delay line that keeps the rotated directions level with the wrap unit.
  localparam int WRAP_LAT  = 34;
  // Register stages of the separating-axis test.
  localparam int SAT_LAT   = 7;
  // Cycles from an accepted start to the cycle in which done is high.
  localparam int TOTAL_LAT = WRAP_LAT + SAT_LAT + 1;

  // Rotated edge directions of both squares, signed Q5.28.
  typedef struct packed {
    logic signed [32:0] c1;
    logic signed [32:0] s1;
    logic signed [32:0] c2;
    logic signed [32:0] s2;
  } psot_dir_t;

endpackage

/* hw/rtl/periodic_square_overlap_test.sv */
// Channel   Ports                                            Transfer
// command   start, busy, first_*, second_*                   start high, busy low
// result    done, overlap                                    done high, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid and cfg_ready high
//
// A new square pair is taken every cycle; busy is never raised.
// A start passes first through the minimum-image wrap, with its 32 remainder
// stages, and then through the products and compares of the test.
// Synchronous reset clears the valid bits of the pipeline and restores the registers.
// The receiver cannot stall, so the pipeline always advances.
module periodic_square_overlap_test
  import psot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        first_x,
  input  logic [31:0]        first_y,
  input  logic signed [15:0] first_qs,
  input  logic signed [15:0] first_qc,
  input  logic [31:0]        second_x,
  input  logic [31:0]        second_y,
  input  logic signed [15:0] second_qs,
  input  logic signed [15:0] second_qc,
  output logic               done,
  output logic               overlap,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0]        box_width, box_height;
  logic [22:0]        side_length;
  logic               accept;
  logic               vx, vy;
  logic signed [32:0] dx, dy;
  psot_dir_t          dir;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width   <= BOX_RESET;
      box_height  <= BOX_RESET;
      side_length <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_WIDTH:   box_width   <= cfg_data;
        REG_BOX_HEIGHT:  box_height  <= cfg_data;
        REG_SIDE_LENGTH: side_length <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  psot_wrap u_wrap_x (
    .clk(clk), .rst(rst), .in_valid(accept),
    .a(first_x), .b(second_x), .box(box_width),
    .out_valid(vx), .d(dx)
  );

  psot_wrap u_wrap_y (
    .clk(clk), .rst(rst), .in_valid(accept),
    .a(first_y), .b(second_y), .box(box_height),
    .out_valid(vy), .d(dy)
  );

  psot_dir u_dir (
    .clk(clk), .aqs(first_qs), .aqc(first_qc),
    .bqs(second_qs), .bqc(second_qc), .dir(dir)
  );

  psot_sat u_sat (
    .clk(clk), .rst(rst), .in_valid(vx && vy),
    .dx(dx), .dy(dy), .dir(dir), .side(side_length),
    .out_valid(done), .overlap(overlap)
  );

endmodule

/* hw/rtl/psot_wrap.sv */
module psot_wrap
  import psot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        box,
  output logic               out_valid,
  output logic signed [32:0] d
);

  localparam int STEPS = 32;

  logic              v_s   [0:STEPS];
  logic              neg_s [0:STEPS];
  logic [31:0]       rem_s [0:STEPS];
  logic [32:0]       len_s [0:STEPS];

  logic signed [32:0] raw;
  logic               f_v;
  logic [32:0]        f_r;
  logic [32:0]        f_len;
  logic               o_v;

  assign raw = $signed({1'b0, b}) - $signed({1'b0, a});

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= in_valid;
    end
    neg_s[0] <= raw[32];
    rem_s[0] <= raw[32] ? 32'(-raw) : raw[31:0];
    len_s[0] <= (box == 32'd0) ? 33'h1_0000_0000 : {1'b0, box};
  end

  // One restoring remainder step per stage, most significant multiple first.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [64:0] sub;
    logic        take;
    assign sub  = {32'd0, len_s[j]} << (STEPS - 1 - j);
    assign take = {33'd0, rem_s[j]} >= sub;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else begin
        v_s[j+1] <= v_s[j];
      end
      neg_s[j+1] <= neg_s[j];
      len_s[j+1] <= len_s[j];
      rem_s[j+1] <= take ? rem_s[j] - sub[31:0] : rem_s[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      f_v <= v_s[STEPS];
      o_v <= f_v;
    end
    f_len <= len_s[STEPS];
    if (neg_s[STEPS] && rem_s[STEPS] != 32'd0) begin
      f_r <= len_s[STEPS] - {1'b0, rem_s[STEPS]};
    end else begin
      f_r <= {1'b0, rem_s[STEPS]};
    end
    // An offset of exactly half the box stays positive.
    if ({f_r, 1'b0} > {1'b0, f_len}) begin
      d <= $signed(f_r - f_len);
    end else begin
      d <= $signed(f_r);
    end
  end

  assign out_valid = o_v;

endmodule

/* hw/rtl/psot_dir.sv */
module psot_dir
  import psot_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] aqs,
  input  logic signed [15:0] aqc,
  input  logic signed [15:0] bqs,
  input  logic signed [15:0] bqc,
  output psot_dir_t          dir
);

  localparam int DEPTH = WRAP_LAT;

  logic signed [31:0] acc, ass, asc, bcc, bss, bsc;
  psot_dir_t          line [0:DEPTH-1];

  always_ff @(posedge clk) begin
    acc <= aqc * aqc;
    ass <= aqs * aqs;
    asc <= aqs * aqc;
    bcc <= bqc * bqc;
    bss <= bqs * bqs;
    bsc <= bqs * bqc;
    line[0].c1 <= 33'(acc) - 33'(ass);
    line[0].s1 <= {asc, 1'b0};
    line[0].c2 <= 33'(bcc) - 33'(bss);
    line[0].s2 <= {bsc, 1'b0};
  end

  // Delay line that keeps the directions level with the wrapped offsets.
  for (genvar k = 1; k < DEPTH; k++) begin : g_dly
    always_ff @(posedge clk) begin
      line[k] <= line[k-1];
    end
  end

  assign dir = line[DEPTH-1];

endmodule

/* hw/rtl/psot_sat.sv */
module psot_sat
  import psot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  input  psot_dir_t          dir,
  input  logic [22:0]        side,
  output logic               out_valid,
  output logic               overlap
);

  logic [SAT_LAT-1:0] v;

  // Stage 1: all products.
  logic signed [65:0] pxc1, pys1, pxs1, pyc1, pxc2, pys2, pxs2, pyc2;
  logic signed [65:0] c1c1, s1s1, c2c2, s2s2, c1c2, s1s2, c1s2, s1c2;
  // Stage 2: projections.
  logic signed [66:0] g [0:3];
  logic signed [66:0] n1, n2, pp, qq;
  // Stage 3: magnitudes.
  logic [63:0] gap3 [0:3];
  logic [63:0] n1_3, n2_3, epq;
  // Stage 4: extents.
  logic [63:0] gap4 [0:3];
  logic [63:0] ext1, ext2;
  // Stage 5: partial products of side times extent.
  logic [63:0] gap5 [0:3];
  logic [54:0] lo1, hi1, lo2, hi2;
  // Stage 6: full right-hand sides.
  logic [63:0] gap6 [0:3];
  logic [86:0] rhs1, rhs2;
  logic [3:0]  exceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[SAT_LAT-2:0], in_valid};
    end

    pxc1 <= dx * dir.c1;  pys1 <= dy * dir.s1;
    pxs1 <= dx * dir.s1;  pyc1 <= dy * dir.c1;
    pxc2 <= dx * dir.c2;  pys2 <= dy * dir.s2;
    pxs2 <= dx * dir.s2;  pyc2 <= dy * dir.c2;
    c1c1 <= dir.c1 * dir.c1;  s1s1 <= dir.s1 * dir.s1;
    c2c2 <= dir.c2 * dir.c2;  s2s2 <= dir.s2 * dir.s2;
    c1c2 <= dir.c1 * dir.c2;  s1s2 <= dir.s1 * dir.s2;
    c1s2 <= dir.c1 * dir.s2;  s1c2 <= dir.s1 * dir.c2;

    g[0] <= 67'(pxc1) + 67'(pys1);
    g[1] <= 67'(pyc1) - 67'(pxs1);
    g[2] <= 67'(pxc2) + 67'(pys2);
    g[3] <= 67'(pyc2) - 67'(pxs2);
    n1   <= 67'(c1c1) + 67'(s1s1);
    n2   <= 67'(c2c2) + 67'(s2s2);
    pp   <= 67'(c1c2) + 67'(s1s2);
    qq   <= 67'(c1s2) - 67'(s1c2);

    for (int i = 0; i < 4; i++) begin
      gap3[i] <= g[i][66] ? 64'(-g[i]) : g[i][63:0];
      gap4[i] <= gap3[i];
      gap5[i] <= gap4[i];
      gap6[i] <= gap5[i];
    end
    n1_3 <= n1[63:0];
    n2_3 <= n2[63:0];
    // Cross terms are shared by all four axes; the own-square terms give n and zero.
    epq  <= (pp[66] ? 64'(-pp) : pp[63:0]) + (qq[66] ? 64'(-qq) : qq[63:0]);

    ext1 <= n1_3 + epq;
    ext2 <= n2_3 + epq;

    lo1 <= side * ext1[31:0];
    hi1 <= side * ext1[63:32];
    lo2 <= side * ext2[31:0];
    hi2 <= side * ext2[63:32];

    rhs1 <= 87'(lo1) + (87'(hi1) << 32);
    rhs2 <= 87'(lo2) + (87'(hi2) << 32);

    // A zero side always counts as overlap; zero normals never separate.
    overlap <= (side == 23'd0) || (exceed == 4'd0);
  end

  always_comb begin
    exceed[0] = {gap6[0], 29'd0} > 93'(rhs1);
    exceed[1] = {gap6[1], 29'd0} > 93'(rhs1);
    exceed[2] = {gap6[2], 29'd0} > 93'(rhs2);
    exceed[3] = {gap6[3], 29'd0} > 93'(rhs2);
  end

  assign out_valid = v[SAT_LAT-1];

endmodule

/* hw/rtl/psot_check.sv */
module psot_check
  import psot_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  // Every accepted pair gives its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result missing after accepted start");

  // No result is invented.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without matching start");

  // The pipeline never holds off a command.
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result straight after reset");

  a_cfg_ready: assert property (@(posedge clk) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind periodic_square_overlap_test psot_check u_psot_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .cfg_ready(cfg_ready)
);

/* bench/tb_top.sv */
module tb_top
  import psot_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]        first_x;
    logic [31:0]        first_y;
    logic signed [15:0] first_qs;
    logic signed [15:0] first_qc;
    logic [31:0]        second_x;
    logic [31:0]        second_y;
    logic signed [15:0] second_qs;
    logic signed [15:0] second_qc;
  } pair_t;

  class overlap_scoreboard;
    logic [31:0] box_w;
    logic [31:0] box_h;
    logic [22:0] side;
    bit          expected_overlaps[$];
    int          errors;

    function new();
      box_w = BOX_RESET;
      box_h = BOX_RESET;
      side = SIDE_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_BOX_WIDTH:   box_w = data;
        REG_BOX_HEIGHT:  box_h = data;
        REG_SIDE_LENGTH: side = data[22:0];
        default: ;
      endcase
    endfunction

    // Minimum-image offset of b from a; exactly half the box stays positive.
    function longint wrap_offset(logic [31:0] a, logic [31:0] b, logic [31:0] box);
      longint len;
      longint raw;
      longint r;
      len = (box == 0) ? 64'h1_0000_0000 : longint'({32'b0, box});
      raw = longint'({32'b0, b}) - longint'({32'b0, a});
      if (raw >= 0) begin
        r = raw % len;
      end else begin
        r = (-raw) % len;
        if (r != 0) r = len - r;
      end
      if (2 * r > len) return r - len;
      return r;
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function bit squares_overlap(pair_t p);
      longint dx, dy;
      longint aqs, aqc, bqs, bqc;
      longint dir_x[4];
      longint dir_y[4];
      logic [63:0] gap;
      logic [63:0] extent;
      logic [127:0] lhs, rhs;
      dx = wrap_offset(p.first_x, p.second_x, box_w);
      dy = wrap_offset(p.first_y, p.second_y, box_h);
      aqs = p.first_qs;
      aqc = p.first_qc;
      bqs = p.second_qs;
      bqc = p.second_qc;
      dir_x[0] = aqc * aqc - aqs * aqs;
      dir_y[0] = 2 * aqs * aqc;
      dir_x[1] = -dir_y[0];
      dir_y[1] = dir_x[0];
      dir_x[2] = bqc * bqc - bqs * bqs;
      dir_y[2] = 2 * bqs * bqc;
      dir_x[3] = -dir_y[2];
      dir_y[3] = dir_x[2];
      if (side == 0) return 1'b1;
      for (int i = 0; i < 4; i++) begin
        gap = magnitude(dx * dir_x[i] + dy * dir_y[i]);
        extent = 0;
        for (int j = 0; j < 4; j++)
          extent += magnitude(dir_x[j] * dir_x[i] + dir_y[j] * dir_y[i]);
        lhs = {64'b0, gap} << 29;
        rhs = {105'b0, side} * {64'b0, extent};
        if (lhs > rhs) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pair(pair_t p);
      expected_overlaps.push_back(squares_overlap(p));
    endfunction

    function void check_overlap(bit actual);
      bit exp_val;
      if (expected_overlaps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual overlap=%0b", $time, actual);
        errors++;
        return;
      end
      exp_val = expected_overlaps.pop_front();
      if (exp_val !== actual) begin
        $display("%0t: overlap mismatch, expected %0b, actual %0b", $time, exp_val, actual);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic        overlap;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BOX_WIDTH;
  logic [31:0] cfg_data = '0;
  pair_t       pair_in = '0;
  bit          calm = 0;

  overlap_scoreboard sb = new();

  always #5 clk = ~clk;

  periodic_square_overlap_test i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(pair_in.first_x), .first_y(pair_in.first_y),
    .first_qs(pair_in.first_qs), .first_qc(pair_in.first_qc),
    .second_x(pair_in.second_x), .second_y(pair_in.second_y),
    .second_qs(pair_in.second_qs), .second_qc(pair_in.second_qc),
    .done(done), .overlap(overlap),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pair(pair_in);
      if (done) sb.check_overlap(overlap);
    end
  end

  task automatic send_pair(pair_t p);
    if (!calm && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    pair_in <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_overlaps.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic signed [15:0] rand_q();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Half-angle pair close to unit length, so the squares are true squares.
  task automatic unit_pair(output logic signed [15:0] qs, output logic signed [15:0] qc);
    real half;
    half = $urandom_range(0, 62831) / 10000.0;
    qs = 16'($rtoi($sin(half) * 16384.0));
    qc = 16'($rtoi($cos(half) * 16384.0));
  endtask

  function automatic logic [31:0] rand_in_box(logic [31:0] box);
    return (box == 0) ? $urandom : $urandom % box;
  endfunction

  function automatic logic [31:0] near_offset();
    int unsigned span;
    span = 3 * sb.side + 2;
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic random_pairs(int count);
    pair_t p;
    repeat (count) begin
      if ($urandom_range(0, 99) < 75) begin
        p.first_x = rand_in_box(sb.box_w);
        p.first_y = rand_in_box(sb.box_h);
        p.second_x = p.first_x + near_offset();
        p.second_y = p.first_y + near_offset();
        unit_pair(p.first_qs, p.first_qc);
        unit_pair(p.second_qs, p.second_qc);
      end else begin
        p.first_x = $urandom;
        p.first_y = $urandom;
        p.second_x = $urandom;
        p.second_y = $urandom;
        p.first_qs = rand_q();
        p.first_qc = rand_q();
        p.second_qs = rand_q();
        p.second_qc = rand_q();
      end
      send_pair(p);
    end
  endtask

  task automatic directed_pairs();
    pair_t p;
    p = '0;
    send_pair(p);
    p.first_qc = 16384; p.second_qc = 16384;
    send_pair(p);
    // Side by side, exactly touching: counts as overlap.
    p.second_x = 32'h0001_0000;
    send_pair(p);
    p.second_x = 32'h0001_0001;
    send_pair(p);
    // Wrap across the box edge.
    p.first_x = 32'h003F_FF00; p.second_x = 32'h0000_0100;
    send_pair(p);
    // Offset of exactly half the box.
    p.first_x = 0; p.second_x = 32'h0020_0000;
    send_pair(p);
    p.first_x = 32'hFFFF_FFFF; p.first_y = 32'hFFFF_FFFF;
    p.second_x = 0; p.second_y = 0;
    send_pair(p);
    p.first_qs = -16384; p.first_qc = -16384;
    p.second_qs = 16384; p.second_qc = -16384;
    send_pair(p);
    p.first_qs = 11585; p.first_qc = 11585;
    p.second_qs = 0; p.second_qc = 16384;
    p.first_x = 0; p.first_y = 0;
    p.second_x = 32'h0001_6000; p.second_y = 0;
    send_pair(p);
    p.second_x = 32'h0001_C000;
    send_pair(p);
    // Collapsed square from a zero rotation pair.
    p.first_qs = 0; p.first_qc = 0;
    send_pair(p);
    p.second_qs = 0; p.second_qc = 0;
    p.second_x = 32'h0100_0000;
    send_pair(p);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_pairs();
    random_pairs(250);

    drain();
    write_reg(REG_SIDE_LENGTH, 23'd4194304);
    write_reg(REG_BOX_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_BOX_HEIGHT, 32'd0);
    random_pairs(200);

    drain();
    write_reg(REG_SIDE_LENGTH, 23'd1);
    write_reg(REG_BOX_WIDTH, 32'd1);
    write_reg(REG_BOX_HEIGHT, 32'd3);
    random_pairs(100);

    drain();
    write_reg(REG_SIDE_LENGTH, 23'd0);
    random_pairs(50);

    drain();
    write_reg(REG_SIDE_LENGTH, 23'h0002_8000);
    write_reg(REG_BOX_WIDTH, 32'h0008_0000);
    write_reg(REG_BOX_HEIGHT, 32'h000A_0000);
    calm = 1;
    random_pairs(250);
    calm = 0;

    drain();
    write_reg(REG_SIDE_LENGTH, 23'd4194304);
    write_reg(REG_BOX_WIDTH, 32'd4194304);
    write_reg(REG_BOX_HEIGHT, 32'd12345678);
    random_pairs(250);

    drain();
    if (sb.errors == 0 && sb.expected_overlaps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/psot_pkg.sv
hw/rtl/psot_wrap.sv
hw/rtl/psot_dir.sv
hw/rtl/psot_sat.sv
hw/rtl/periodic_square_overlap_test.sv
hw/rtl/psot_check.sv
bench/tb_top.sv
